// ----- rtl/trct_pkg.sv -----
// Types and constants shared by the tag reuse counter table.
`default_nettype none
package trct_pkg;

  localparam int unsigned TAG_W   = 15;
  localparam int unsigned COMM_W  = 8;
  localparam int unsigned PEER_W  = 6;
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic              kind;
    logic [PEER_W-1:0] peer_rank;
    logic [TAG_W-1:0]  msg_tag;
    logic [COMM_W-1:0] comm_id;
  } trct_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] use_count;
    logic               list_full;
  } trct_rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]   msg_tag;
    logic [COMM_W-1:0]  comm_id;
    logic [COUNT_W-1:0] use_count;
  } trct_entry_t;

  localparam int unsigned ENTRY_W = $bits(trct_entry_t);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_SCAN
  } trct_state_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic load_fill;
    logic scan;
  } trct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic scan_end;
  } trct_sts_t;

endpackage
`default_nettype wire

// ----- rtl/trct_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none
module trct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/trct_ctrl.sv -----
// Controller state machine: clearing pass, request accept, fill read and list scan.
`default_nettype none
module trct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire trct_pkg::trct_sts_t sts,
  output logic                    busy,
  output trct_pkg::trct_cmd_t     cmd
);

  trct_pkg::trct_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trct_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      trct_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = trct_pkg::S_IDLE;
        end
      end
      trct_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.in_range) begin
            state_nxt = trct_pkg::S_FILL;
          end
        end
      end
      trct_pkg::S_FILL: begin
        cmd.load_fill = 1'b1;
        state_nxt     = trct_pkg::S_SCAN;
      end
      trct_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = trct_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = trct_pkg::S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/trct_dp.sv -----
// Datapath: fill level and entry memories, pipelined list scan, result register.
`default_nettype none
module trct_dp #(
  parameter int unsigned NUM_PEERS  = 64,
  parameter int unsigned LIST_DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire trct_pkg::trct_req_t in_req,
  input  wire trct_pkg::trct_cmd_t cmd,
  output trct_pkg::trct_sts_t      sts,
  output logic                     out_valid,
  output trct_pkg::trct_rsp_t      out_rsp
);

  localparam int unsigned NUM_LISTS = 2 * NUM_PEERS;
  localparam int unsigned LIST_W    = $clog2(NUM_LISTS);
  localparam int unsigned SLOT_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FILL_W    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ENT_DEPTH = NUM_LISTS * (2 ** SLOT_W);

  trct_pkg::trct_req_t req_r, req_nxt;
  logic [LIST_W-1:0]   list_r, list_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FILL_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [LIST_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  trct_pkg::trct_rsp_t out_rsp_r, out_rsp_nxt;

  logic [LIST_W-1:0]   in_list;
  logic                in_range;
  logic                match, hit, issue, miss, full;
  logic [15:0]         new_count;
  trct_pkg::trct_entry_t ent_rd, ent_wr;
  logic [trct_pkg::ENTRY_W-1:0] ent_rdata;
  logic [SLOT_W-1:0]   ent_slot;
  logic                ent_we;
  logic [LIST_W-1:0]   fill_addr;
  logic [FILL_W-1:0]   fill_wdata, fill_rdata;
  logic                fill_we;

  assign in_range = 32'(in_req.peer_rank) < NUM_PEERS;
  assign in_list  = LIST_W'(in_req.peer_rank)
                  + (in_req.kind ? LIST_W'(NUM_PEERS) : LIST_W'(0));

  assign ent_rd = trct_pkg::trct_entry_t'(ent_rdata);
  assign match  = cmp_vld_r && (ent_rd.msg_tag == req_r.msg_tag)
                            && (ent_rd.comm_id == req_r.comm_id);
  assign hit    = cmd.scan && match;
  assign issue  = cmd.scan && !match && (idx_r < fill_r);
  assign miss   = cmd.scan && !match && !(idx_r < fill_r);
  assign full   = fill_r == FILL_W'(LIST_DEPTH);

  assign new_count = (ent_rd.use_count == trct_pkg::COUNT_MAX) ?
                     trct_pkg::COUNT_MAX : ent_rd.use_count + 16'd1;

  // entry memory: read in scan, write back on hit, append on miss when the list is not full
  always_comb begin
    ent_wr.msg_tag = req_r.msg_tag;
    ent_wr.comm_id = req_r.comm_id;
    if (hit) begin
      ent_wr.use_count = new_count;
      ent_slot         = cmp_idx_r;
    end else if (issue) begin
      ent_wr.use_count = new_count;
      ent_slot         = idx_r[SLOT_W-1:0];
    end else begin
      ent_wr.use_count = 16'd1;
      ent_slot         = fill_r[SLOT_W-1:0];
    end
  end
  assign ent_we = hit || (miss && !full);

  trct_ram #(
    .WIDTH (trct_pkg::ENTRY_W),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .addr  ({list_r, ent_slot}),
    .wdata (ent_wr),
    .rdata (ent_rdata)
  );

  // fill level memory, swept to zero after reset
  assign fill_we    = cmd.clr || (miss && !full);
  assign fill_wdata = cmd.clr ? '0 : fill_r + FILL_W'(1);
  assign fill_addr  = cmd.clr ? clr_cnt_r : (cmd.accept ? in_list : list_r);

  trct_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_LISTS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .addr  (fill_addr),
    .wdata (fill_wdata),
    .rdata (fill_rdata)
  );

  always_comb begin
    req_nxt       = req_r;
    list_nxt      = list_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    if (cmd.clr) begin
      clr_cnt_nxt = clr_cnt_r + LIST_W'(1);
    end
    if (cmd.accept) begin
      req_nxt  = in_req;
      list_nxt = in_list;
      if (!in_range) begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.use_count = '0;
        out_rsp_nxt.list_full = 1'b1;
      end
    end
    if (cmd.load_fill) begin
      fill_nxt    = fill_rdata;
      idx_nxt     = '0;
      cmp_vld_nxt = 1'b0;
    end
    if (cmd.scan) begin
      cmp_vld_nxt = issue;
      cmp_idx_nxt = idx_r[SLOT_W-1:0];
      if (issue) begin
        idx_nxt = idx_r + FILL_W'(1);
      end
      if (hit) begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.use_count = new_count;
        out_rsp_nxt.list_full = 1'b0;
      end else if (miss) begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.use_count = full ? 16'd0 : 16'd1;
        out_rsp_nxt.list_full = full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r   <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r   <= cmp_vld_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    list_r    <= list_nxt;
    fill_r    <= fill_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign sts.clr_last = clr_cnt_r == LIST_W'(NUM_LISTS - 1);
  assign sts.in_range = in_range;
  assign sts.scan_end = hit || miss;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

// ----- rtl/tag_reuse_counter_table.sv -----
// Tag reuse counter table: per direction and peer lists of tag/communicator use counts.
// After accept the fill level is read, then the scan reads one entry a cycle through the
// single-port entry memory and ends on a match or past the last filled entry; a peer_rank
// out of range is answered in the cycle after accept. Busy is high from fill to scan end,
// so a new transaction is taken only once the last one ends. Reset: a clearing pass
// zeroes the fill levels, busy high. Results cannot be stalled; out_valid marks each for
// one cycle.
`default_nettype none
module tag_reuse_counter_table #(
  parameter int unsigned NUM_PEERS  = 64,
  parameter int unsigned LIST_DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire trct_pkg::trct_req_t in_req,
  output logic                     out_valid,
  output trct_pkg::trct_rsp_t      out_rsp
);

  trct_pkg::trct_cmd_t cmd;
  trct_pkg::trct_sts_t sts;

  trct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  trct_dp #(
    .NUM_PEERS  (NUM_PEERS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire
